FILE: rtl/glp_pkg.sv
package glp_pkg;

  // grid size limits
  localparam int MaxRows = 16;
  localparam int MaxCols = 16;
  localparam int CellCap = MaxRows * MaxCols;

  // field widths
  localparam int ValW = 32;
  localparam int LenW = 9;
  localparam int DimW = 5;

  // derived widths
  localparam int AddrW = (CellCap > 1) ? $clog2(CellCap) : 1;
  localparam int CntW  = $clog2(CellCap + 1);
  localparam int RowW  = $clog2(MaxRows + 1);
  localparam int ColW  = $clog2(MaxCols + 1);
  localparam int RIdxW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int CIdxW = (MaxCols > 1) ? $clog2(MaxCols) : 1;

  // configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgRowCount    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgColumnCount = CfgIdxW'(1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_HOLD
  } state_e;

  // one cell visit: read self, then four neighbors, then write back
  typedef enum logic [2:0] {
    STEP_OWN,
    STEP_DOWN,
    STEP_UP,
    STEP_RIGHT,
    STEP_LEFT,
    STEP_WB
  } step_e;

endpackage

FILE: rtl/grid_longest_increasing_path_unit.sv
// channel   | handshake                 | payload
// ----------+---------------------------+-----------------------------
// cell in   | in_valid_i / in_stall_o   | cell_value_i  (32b signed)
// result    | out_valid_o / out_stall_i | path_length_o (9b unsigned)
// config    | cfg_we_i                  | cfg_index_i, cfg_data_i (5b)
//
// cells load one per cycle into the grid memory until rows*columns have arrived
// the search then visits every cell once per relaxation pass, reading it and its
// four neighbors one by one, as set by the single read port of each memory, then
// writing back; passes repeat until one changes nothing, input held off meanwhile
// reset clears the load count and restores 16 x 16; memories are not cleared
// a stalled result sits in its output register while the next grid loads
module grid_longest_increasing_path_unit import glp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [ValW-1:0] cell_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic        [LenW-1:0] path_length_o,
  input  logic                   cfg_we_i,
  input  logic     [CfgIdxW-1:0] cfg_index_i,
  input  logic        [DimW-1:0] cfg_data_i
);

  // grid values and per-cell longest path lengths, one read port each
  logic signed [ValW-1:0] grid_mem [CellCap];
  logic        [LenW-1:0] len_mem  [CellCap];

  state_e                 state_q, state_d;
  step_e                  step_q, step_d;
  logic      [RowW-1:0]   rows_q, rows_d;
  logic      [ColW-1:0]   cols_q, cols_d;
  logic      [CntW-1:0]   loaded_q, loaded_d;
  logic      [AddrW-1:0]  k_q, k_d;
  logic      [RIdxW-1:0]  r_q, r_d;
  logic      [CIdxW-1:0]  c_q, c_d;
  logic signed [ValW-1:0] own_val_q, own_val_d;
  logic      [LenW-1:0]   own_len_q, own_len_d;
  logic      [LenW-1:0]   top_q, top_d;
  logic      [LenW-1:0]   best_q, best_d;
  logic                   changed_q, changed_d;
  logic                   rd_ok_q, rd_ok_d;
  logic                   out_valid_q, out_valid_d;
  logic      [LenW-1:0]   out_len_q, out_len_d;

  logic signed [ValW-1:0] rd_val_q;
  logic      [LenW-1:0]   rd_len_q;
  logic      [AddrW-1:0]  rd_addr;
  logic      [AddrW-1:0]  wr_addr;
  logic                   grid_we;
  logic                   len_we;
  logic      [LenW-1:0]   len_wdata;

  logic      [CntW-1:0]   total;
  logic                   in_acc;
  logic                   can_publish;
  logic                   last_row, last_col, last_cell;
  logic      [LenW:0]     sum;
  logic      [LenW-1:0]   cand;
  logic      [LenW-1:0]   new_len;
  logic                   wr_len;

  function automatic logic [RowW-1:0] clamp_rows(logic [DimW-1:0] v);
    if (v == '0) return RowW'(1);
    if (int'(v) > MaxRows) return RowW'(MaxRows);
    return RowW'(v);
  endfunction

  function automatic logic [ColW-1:0] clamp_cols(logic [DimW-1:0] v);
    if (v == '0) return ColW'(1);
    if (int'(v) > MaxCols) return ColW'(MaxCols);
    return ColW'(v);
  endfunction

  assign total       = CntW'(rows_q) * CntW'(cols_q);
  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign can_publish = !out_valid_q || !out_stall_i;

  assign last_row  = (RowW'(r_q) + RowW'(1)) == rows_q;
  assign last_col  = (ColW'(c_q) + ColW'(1)) == cols_q;
  assign last_cell = (CntW'(k_q) + CntW'(1)) == total;

  assign out_valid_o   = out_valid_q;
  assign path_length_o = out_len_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    rows_d      = rows_q;
    cols_d      = cols_q;
    loaded_d    = loaded_q;
    k_d         = k_q;
    r_d         = r_q;
    c_d         = c_q;
    own_val_d   = own_val_q;
    own_len_d   = own_len_q;
    top_d       = top_q;
    best_d      = best_q;
    changed_d   = changed_q;
    rd_ok_d     = 1'b0;
    rd_addr     = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_len_d   = out_len_q;
    grid_we     = 1'b0;
    len_we      = 1'b0;
    wr_addr     = loaded_q[AddrW-1:0];
    len_wdata   = LenW'(1);
    sum         = '0;
    cand        = '0;
    new_len     = own_len_q;
    wr_len      = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        // each loaded cell also seeds its path length with one
        if (in_acc) begin
          grid_we = 1'b1;
          len_we  = 1'b1;
          if (loaded_q + CntW'(1) == total) begin
            loaded_d  = '0;
            state_d   = ST_SEARCH;
            step_d    = STEP_OWN;
            k_d       = '0;
            r_d       = '0;
            c_d       = '0;
            changed_d = 1'b0;
            best_d    = '0;
          end else begin
            loaded_d = loaded_q + CntW'(1);
          end
        end
      end

      ST_SEARCH: begin
        // read data arrives in the cycle after its address; each step between the own
        // read and the write back consumes the previous read and issues the next one
        if (step_q != STEP_OWN && step_q != STEP_DOWN) begin
          if (rd_ok_q && (rd_val_q > own_val_q) && (rd_len_q > top_q)) begin
            top_d = rd_len_q;
          end
        end
        unique case (step_q)
          STEP_OWN: begin
            top_d   = '0;
            rd_addr = k_q;
            step_d  = STEP_DOWN;
          end
          STEP_DOWN: begin
            own_val_d = rd_val_q;
            own_len_d = rd_len_q;
            rd_ok_d   = !last_row;
            rd_addr   = last_row ? k_q : k_q + AddrW'(cols_q);
            step_d    = STEP_UP;
          end
          STEP_UP: begin
            rd_ok_d = (r_q != '0);
            rd_addr = (r_q != '0) ? k_q - AddrW'(cols_q) : k_q;
            step_d  = STEP_RIGHT;
          end
          STEP_RIGHT: begin
            rd_ok_d = !last_col;
            rd_addr = last_col ? k_q : k_q + AddrW'(1);
            step_d  = STEP_LEFT;
          end
          STEP_LEFT: begin
            rd_ok_d = (c_q != '0);
            rd_addr = (c_q != '0) ? k_q - AddrW'(1) : k_q;
            step_d  = STEP_WB;
          end
          STEP_WB: begin
            // the read issued here is never consumed, so its meeting the write back
            // to the same entry is harmless
            sum     = {1'b0, top_d} + (LenW + 1)'(1);
            cand    = sum[LenW] ? '1 : sum[LenW-1:0];
            wr_len  = cand > own_len_q;
            new_len = wr_len ? cand : own_len_q;
            len_we    = wr_len;
            wr_addr   = k_q;
            len_wdata = cand;
            best_d    = (new_len > best_q) ? new_len : best_q;
            changed_d = changed_q || wr_len;
            step_d    = STEP_OWN;
            if (last_cell) begin
              k_d = '0;
              r_d = '0;
              c_d = '0;
              if (changed_d) begin
                // another pass
                changed_d = 1'b0;
                best_d    = '0;
              end else if (can_publish) begin
                out_valid_d = 1'b1;
                out_len_d   = best_d;
                state_d     = ST_LOAD;
              end else begin
                state_d = ST_HOLD;
              end
            end else begin
              k_d = k_q + AddrW'(1);
              if (last_col) begin
                c_d = '0;
                r_d = r_q + RIdxW'(1);
              end else begin
                c_d = c_q + CIdxW'(1);
              end
            end
          end
          default: step_d = STEP_OWN;
        endcase
      end

      ST_HOLD: begin
        // previous result still waiting downstream
        if (can_publish) begin
          out_valid_d = 1'b1;
          out_len_d   = best_q;
          state_d     = ST_LOAD;
        end
      end

      default: state_d = ST_LOAD;
    endcase

    // any register write drops a partly loaded grid
    if (cfg_we_i) begin
      loaded_d = '0;
      if (cfg_index_i == CfgRowCount) begin
        rows_d = clamp_rows(cfg_data_i);
      end else begin
        cols_d = clamp_cols(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      step_q      <= STEP_OWN;
      rows_q      <= clamp_rows(DimW'(16));
      cols_q      <= clamp_cols(DimW'(16));
      loaded_q    <= '0;
      k_q         <= '0;
      r_q         <= '0;
      c_q         <= '0;
      changed_q   <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      loaded_q    <= loaded_d;
      k_q         <= k_d;
      r_q         <= r_d;
      c_q         <= c_d;
      changed_q   <= changed_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    own_val_q <= own_val_d;
    own_len_q <= own_len_d;
    top_q     <= top_d;
    best_q    <= best_d;
    out_len_q <= out_len_d;
  end

  // memories with registered read data
  always_ff @(posedge clk_i) begin
    if (grid_we) begin
      grid_mem[wr_addr] <= cell_value_i;
    end
    if (len_we) begin
      len_mem[wr_addr] <= len_wdata;
    end
    rd_val_q <= grid_mem[rd_addr];
    rd_len_q <= len_mem[rd_addr];
  end

endmodule

FILE: rtl/glp_checker.sv
module glp_checker import glp_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic signed [ValW-1:0] cell_value_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic        [LenW-1:0] path_length_o,
  input logic                   cfg_we_i,
  input logic     [CfgIdxW-1:0] cfg_index_i,
  input logic        [DimW-1:0] cfg_data_i
);

  // held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(path_length_o))
    else $error("stalled result changed");

  // every cell is a path of at least one
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> path_length_o != '0)
    else $error("zero path length");

  // the search only starts right after an accepted cell
  a_search_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("input held off without a final cell");

  // a new result only comes out of the search
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised outside the search");

endmodule

bind grid_longest_increasing_path_unit glp_checker u_glp_checker (.*);

FILE: tb/sv/grid_path_checker.sv
module grid_path_checker import glp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic signed [ValW-1:0] cell_value_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic        [LenW-1:0] path_length_i,
  input  logic                   cfg_we_i,
  input  logic     [CfgIdxW-1:0] cfg_index_i,
  input  logic        [DimW-1:0] cfg_data_i,
  input  logic                   end_check_i,
  output int                     pending_o,
  output int                     fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [ValW-1:0] cell_mem [CellCap];
  logic [LenW-1:0] expected_lengths [$];
  int unsigned grid_rows = MaxRows;
  int unsigned grid_cols = MaxCols;
  int unsigned cells_in = 0;
  int mismatch_count = 0;
  int waiting = 0;

  // zero reads as one, oversize reads as the maximum
  function automatic int unsigned fit_dim(input logic [DimW-1:0] raw, input int unsigned cap);
    if (raw == '0) return 1;
    if (raw > cap) return cap;
    return raw;
  endfunction

  // relax path lengths over the loaded grid until they settle
  function automatic logic [LenW-1:0] longest_rising_path(input int unsigned nr,
                                                          input int unsigned nc);
    int unsigned run_len [CellCap];
    int unsigned total, best, top, r, c, k;
    bit changed;
    total = nr * nc;
    best = 1;
    for (k = 0; k < total; k++) run_len[k] = 1;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (k = 0; k < total; k++) begin
        r = k / nc;
        c = k % nc;
        top = 0;
        if (r + 1 < nr && cell_mem[k + nc] > cell_mem[k] && run_len[k + nc] > top)
          top = run_len[k + nc];
        if (r > 0 && cell_mem[k - nc] > cell_mem[k] && run_len[k - nc] > top)
          top = run_len[k - nc];
        if (c + 1 < nc && cell_mem[k + 1] > cell_mem[k] && run_len[k + 1] > top)
          top = run_len[k + 1];
        if (c > 0 && cell_mem[k - 1] > cell_mem[k] && run_len[k - 1] > top)
          top = run_len[k - 1];
        if (top + 1 > run_len[k]) begin
          run_len[k] = top + 1;
          changed = 1'b1;
        end
      end
    end
    for (k = 0; k < total; k++) if (run_len[k] > best) best = run_len[k];
    if (best > (1 << LenW) - 1) best = (1 << LenW) - 1;
    return LenW'(best);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [LenW-1:0] want;
    if (!rst_ni) begin
      grid_rows = MaxRows;
      grid_cols = MaxCols;
      cells_in = 0;
      expected_lengths.delete();
      waiting = 0;
      pending_o <= 0;
    end else begin
      // a register write drops any partly loaded grid
      if (cfg_we_i) begin
        if (cfg_index_i == CfgRowCount) grid_rows = fit_dim(cfg_data_i, MaxRows);
        if (cfg_index_i == CfgColumnCount) grid_cols = fit_dim(cfg_data_i, MaxCols);
        cells_in = 0;
      end
      if (in_valid_i && !in_stall_i) begin
        if (cells_in >= grid_rows * grid_cols) cells_in = 0;
        cell_mem[cells_in] = cell_value_i;
        cells_in++;
        if (cells_in == grid_rows * grid_cols) begin
          expected_lengths.push_back(longest_rising_path(grid_rows, grid_cols));
          cells_in = 0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_lengths.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected path length %0d, nothing outstanding", path_length_i);
        end else begin
          want = expected_lengths.pop_front();
          if (path_length_i !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("path length mismatch: expected %0d, got %0d", want, path_length_i);
          end
        end
      end
      waiting = expected_lengths.size();
      pending_o <= waiting;
    end
  end

  assign fail_count_o = mismatch_count + (end_check_i ? waiting : 0);

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import glp_pkg::*;

  // content shapes for one grid
  typedef enum int {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_SNAKE,
    FILL_EXTREMES
  } fill_e;

  localparam logic signed [ValW-1:0] CellMin = {1'b1, {(ValW-1){1'b0}}};
  localparam logic signed [ValW-1:0] CellMax = {1'b0, {(ValW-1){1'b1}}};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cell_valid = 1'b0;
  logic                   cell_stall;
  logic signed [ValW-1:0] cell_value = '0;
  logic                   len_valid;
  logic                   len_stall = 1'b0;
  logic        [LenW-1:0] path_length;
  logic                   cfg_we = 1'b0;
  logic     [CfgIdxW-1:0] cfg_index = CfgRowCount;
  logic        [DimW-1:0] cfg_data = '0;
  logic                   end_check = 1'b0;
  int                     pending;
  int                     fail_count;

  // grid size the stimulus is currently building for
  int unsigned cur_rows = MaxRows;
  int unsigned cur_cols = MaxCols;
  int          cells_sent = 0;
  int          gap_odds = 0;
  bit          quiet = 1'b0;

  grid_longest_increasing_path_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (cell_valid),
    .in_stall_o   (cell_stall),
    .cell_value_i (cell_value),
    .out_valid_o  (len_valid),
    .out_stall_i  (len_stall),
    .path_length_o(path_length),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  grid_path_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (cell_valid),
    .in_stall_i   (cell_stall),
    .cell_value_i (cell_value),
    .out_valid_i  (len_valid),
    .out_stall_i  (len_stall),
    .path_length_i(path_length),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .end_check_i  (end_check),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #10 clk = ~clk;

  // one cell request, with an occasional idle burst ahead of it
  task automatic send_cell(input logic signed [ValW-1:0] v);
    if (gap_odds != 0 && !quiet && $urandom_range(1, gap_odds) == 1) begin
      cell_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_value <= v;
    do @(posedge clk); while (cell_stall);
    cells_sent++;
  endtask

  // hold off requests until every path length is back, then let the block settle
  task automatic finish_results();
    cell_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // both size registers, in random order
  task automatic program_dims(input int unsigned rows_eff, input logic [DimW-1:0] rows_raw,
                              input int unsigned cols_eff, input logic [DimW-1:0] cols_raw);
    bit cols_first;
    cols_first = $urandom_range(0, 1);
    cfg_we <= 1'b1;
    cfg_index <= cols_first ? CfgColumnCount : CfgRowCount;
    cfg_data <= cols_first ? cols_raw : rows_raw;
    @(posedge clk);
    cfg_index <= cols_first ? CfgRowCount : CfgColumnCount;
    cfg_data <= cols_first ? rows_raw : cols_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_rows = rows_eff;
    cur_cols = cols_eff;
  endtask

  // encoding of a size: one may go in as zero, the maximum as any value from it upward
  function automatic logic [DimW-1:0] raw_dim(input int unsigned eff, input int unsigned cap);
    if (eff == 1 && $urandom_range(0, 1) == 1) return '0;
    if (eff == cap && $urandom_range(0, 1) == 1) return DimW'($urandom_range(cap, (1 << DimW) - 1));
    return DimW'(eff);
  endfunction

  // one full grid in row-major order
  task automatic send_grid(input fill_e shape);
    int unsigned k, n, r, c, pos, step;
    int base;
    bit falling;
    logic signed [ValW-1:0] v;
    n = cur_rows * cur_cols;
    // snakes only on small grids, the search time grows with path length
    if (shape == FILL_SNAKE && n > 25) shape = FILL_RANDOM;
    base = int'($urandom_range(0, 2_000_000)) - 1_000_000;
    step = $urandom_range(1, 1000);
    falling = $urandom_range(0, 1);
    for (k = 0; k < n; k++) begin
      case (shape)
        FILL_RANDOM: v = $urandom;
        // few distinct values, lots of equal neighbors
        FILL_NARROW: v = ValW'(int'($urandom_range(0, 3)) - 2);
        // boustrophedon ramp, every cell on one path
        FILL_SNAKE: begin
          r = k / cur_cols;
          c = k % cur_cols;
          pos = r * cur_cols + ((r % 2 != 0) ? cur_cols - 1 - c : c);
          v = falling ? base - int'(pos * step) : base + int'(pos * step);
        end
        default: begin
          case ($urandom_range(0, 5))
            0: v = CellMin;
            1: v = CellMax;
            2: v = '0;
            3: v = '1;
            4: v = 1;
            default: v = $urandom;
          endcase
        end
      endcase
      send_cell(v);
    end
  endtask

  // result-side stall bursts, none once the run goes quiet
  initial begin
    int run, burst;
    forever begin
      run = $urandom_range(1, 40);
      repeat (run) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) != 0) begin
        burst = $urandom_range(1, 13);
        len_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        len_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic signed [ValW-1:0] ramp;
    logic [ValW-1:0] ramp_step;
    int unsigned nr, nc, grids, spare, i;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // a few cells into the reset-size grid, dropped by the register write
    repeat (3) send_cell($urandom);
    finish_results();

    // single-cell grids, rows written as zero
    program_dims(1, '0, 1, DimW'(1));
    send_cell(CellMin);
    send_cell(CellMax);
    send_cell('0);
    send_cell('1);
    finish_results();

    // one row, columns written far above the maximum: full-range ramp
    program_dims(1, '0, MaxCols, '1);
    ramp = CellMin;
    ramp_step = {ValW{1'b1}} / (MaxCols - 1);
    for (i = 0; i < MaxCols; i++) begin
      send_cell(ramp);
      ramp = ramp + ramp_step;
    end

    // random phases: new size, then a handful of grids back to back
    while (cells_sent < 1400) begin
      quiet = (cells_sent >= 1150);
      finish_results();
      if ($urandom_range(0, 4) == 0) begin
        // broken grid: partly loaded, then discarded by the next size write
        spare = cur_rows * cur_cols - 1;
        if (spare > 20) spare = 20;
        if (spare > 0) begin
          repeat ($urandom_range(1, spare)) send_cell($urandom);
          finish_results();
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        nr = $urandom_range(1, MaxRows);
        nc = $urandom_range(1, MaxCols);
      end else begin
        nr = $urandom_range(1, 5);
        nc = $urandom_range(1, 5);
      end
      program_dims(nr, raw_dim(nr, MaxRows), nc, raw_dim(nc, MaxCols));
      case ($urandom_range(0, 2))
        0: gap_odds = 0;
        1: gap_odds = 3;
        default: gap_odds = 10;
      endcase
      grids = (nr * nc > 36) ? 1 : $urandom_range(1, 4);
      repeat (grids) send_grid(fill_e'($urandom_range(0, 3)));
    end

    // drain, allow for stragglers, then count leftovers too
    finish_results();
    repeat (50) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #80_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: grid_longest_increasing_path_unit.f
rtl/glp_pkg.sv
rtl/grid_longest_increasing_path_unit.sv
rtl/glp_checker.sv
tb/sv/grid_path_checker.sv
tb/sv/tb_top.sv
